### sv/fgsr_pkg.sv
// ---------------------------------------------------------------------------
// fgsr_pkg
// Types and constants shared by the grid statistics reducer modules.
// ---------------------------------------------------------------------------
package fgsr_pkg;

  localparam int unsigned MAX_CELLS = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned IN_W      = 128;
  localparam int unsigned OUT_W     = 408;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [32:0] S33_MAX = 33'sh0_FFFF_FFFF;
  localparam logic signed [32:0] S33_MIN = 33'sh1_0000_0000;

  // one cell after the product stage
  typedef struct packed {
    logic signed [63:0] vol_prod;
    logic signed [63:0] fx_prod;
    logic signed [63:0] fz_prod;
    logic signed [31:0] depth;
    logic signed [32:0] surf;
    logic        [31:0] abs_x;
    logic        [31:0] abs_z;
    logic               wet;
    logic               bad;
    logic               last;
  } cell_t;

  typedef struct packed {
    logic signed [63:0] total_flow_z;
    logic signed [63:0] total_flow_x;
    logic signed [63:0] volume;
    logic        [31:0] peak_flow_z;
    logic        [31:0] peak_flow_x;
    logic signed [32:0] max_surface;
    logic signed [32:0] min_surface;
    logic [CNT_W-1:0]   dry_count;
    logic [CNT_W-1:0]   wet_count;
    logic signed [31:0] max_depth;
    logic signed [31:0] min_depth;
    logic        [1:0]  status;
  } result_t;

endpackage

### sv/fgsr_cell_prep.sv
// ---------------------------------------------------------------------------
// fgsr_cell_prep
// Input register, then area products, surface, magnitudes and cell checks.
// ---------------------------------------------------------------------------
module fgsr_cell_prep
  import fgsr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            in_tlast,
  output logic            cell_valid,
  input  logic            cell_ready,
  output cell_t           cell_data
);

  logic [31:0]        area_r;
  logic               a_valid_r;
  logic signed [31:0] a_bed_r;
  logic signed [31:0] a_depth_r;
  logic signed [31:0] a_fx_r;
  logic signed [31:0] a_fz_r;
  logic               a_last_r;
  logic               b_valid_r;
  cell_t              b_cell_r;
  cell_t              b_cell_nxt;
  logic               a_ready;
  logic               b_ready;
  logic signed [32:0] area_s;
  logic signed [64:0] vol_full;
  logic signed [64:0] fx_full;
  logic signed [64:0] fz_full;

  assign b_ready   = !b_valid_r || cell_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  assign area_s   = $signed({1'b0, area_r});
  assign vol_full = a_depth_r * area_s;
  assign fx_full  = a_fx_r * area_s;
  assign fz_full  = a_fz_r * area_s;

  always_comb begin
    b_cell_nxt.vol_prod = vol_full[63:0];
    b_cell_nxt.fx_prod  = fx_full[63:0];
    b_cell_nxt.fz_prod  = fz_full[63:0];
    b_cell_nxt.depth    = a_depth_r;
    b_cell_nxt.surf     = {a_bed_r[31], a_bed_r} + {a_depth_r[31], a_depth_r};
    b_cell_nxt.abs_x    = a_fx_r[31] ? (~a_fx_r + 32'd1) : a_fx_r;
    b_cell_nxt.abs_z    = a_fz_r[31] ? (~a_fz_r + 32'd1) : a_fz_r;
    b_cell_nxt.wet      = (a_depth_r > 32'sd0);
    // negative depth, or dry cell carrying momentum
    b_cell_nxt.bad      = a_depth_r[31] ||
                          ((a_depth_r <= 32'sd0) && ((a_fx_r != 32'sd0) || (a_fz_r != 32'sd0)));
    b_cell_nxt.last     = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= 32'd65536;
    end else if (cfg_wr_en) begin
      area_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_tvalid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) begin
      a_bed_r   <= in_tdata[31:0];
      a_depth_r <= in_tdata[63:32];
      a_fx_r    <= in_tdata[95:64];
      a_fz_r    <= in_tdata[127:96];
      a_last_r  <= in_tlast;
    end
    if (b_ready && a_valid_r) begin
      b_cell_r <= b_cell_nxt;
    end
  end

  assign cell_valid = b_valid_r;
  assign cell_data  = b_cell_r;

endmodule

### sv/fgsr_accum.sv
// ---------------------------------------------------------------------------
// fgsr_accum
// Running statistics, saturating sums and the result register.
// ---------------------------------------------------------------------------
module fgsr_accum
  import fgsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cell_valid,
  output logic    cell_ready,
  input  cell_t   cell_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam logic [CNT_W:0] FULL_CNT = (CNT_W+1)'(MAX_CELLS);

  logic signed [31:0] depth_low_r,    depth_low_nxt;
  logic signed [31:0] depth_high_r,   depth_high_nxt;
  logic [CNT_W-1:0]   wet_r,          wet_nxt;
  logic [CNT_W-1:0]   dry_r,          dry_nxt;
  logic signed [32:0] surf_low_r,     surf_low_nxt;
  logic signed [32:0] surf_high_r,    surf_high_nxt;
  logic [31:0]        peak_x_r,       peak_x_nxt;
  logic [31:0]        peak_z_r,       peak_z_nxt;
  logic signed [63:0] vol_sum_r,      vol_sum_nxt;
  logic signed [63:0] fx_sum_r,       fx_sum_nxt;
  logic signed [63:0] fz_sum_r,       fz_sum_nxt;
  logic               invalid_r,      invalid_nxt;
  logic               ovf_r,          ovf_nxt;
  logic               out_valid_r;
  result_t            result_r;
  result_t            result_nxt;
  logic               take;
  logic               full;
  logic               ovf_v;
  logic               ovf_x;
  logic               ovf_z;

  function automatic logic [64:0] sat_add(input logic signed [63:0] acc,
                                          input logic signed [63:0] add);
    logic signed [64:0] s;
    logic [64:0]        r;
    s = {acc[63], acc} + {add[63], add};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 64'sh8000_0000_0000_0000} : {1'b1, 64'sh7FFF_FFFF_FFFF_FFFF};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

  assign cell_ready = !(cell_data.last && out_valid_r && !out_ready);
  assign take       = cell_valid && cell_ready;
  assign full       = ({1'b0, wet_r} + {1'b0, dry_r}) >= FULL_CNT;

  always_comb begin
    depth_low_nxt  = (cell_data.depth < depth_low_r) ? cell_data.depth : depth_low_r;
    depth_high_nxt = (cell_data.depth > depth_high_r) ? cell_data.depth : depth_high_r;
    wet_nxt        = wet_r;
    dry_nxt        = dry_r;
    surf_low_nxt   = surf_low_r;
    surf_high_nxt  = surf_high_r;
    if (cell_data.wet) begin
      if (!full) begin
        wet_nxt = wet_r + CNT_W'(1);
      end
      if (cell_data.surf < surf_low_r) begin
        surf_low_nxt = cell_data.surf;
      end
      if (cell_data.surf > surf_high_r) begin
        surf_high_nxt = cell_data.surf;
      end
    end else if (!full) begin
      dry_nxt = dry_r + CNT_W'(1);
    end
    peak_x_nxt = (cell_data.abs_x > peak_x_r) ? cell_data.abs_x : peak_x_r;
    peak_z_nxt = (cell_data.abs_z > peak_z_r) ? cell_data.abs_z : peak_z_r;
    {ovf_v, vol_sum_nxt} = sat_add(vol_sum_r, cell_data.vol_prod);
    {ovf_x, fx_sum_nxt}  = sat_add(fx_sum_r, cell_data.fx_prod);
    {ovf_z, fz_sum_nxt}  = sat_add(fz_sum_r, cell_data.fz_prod);
    invalid_nxt = invalid_r || full || cell_data.bad;
    ovf_nxt     = ovf_r || ovf_v || ovf_x || ovf_z;

    priority if (invalid_nxt) begin
      result_nxt.status = STATUS_INVALID;
    end else if (ovf_nxt) begin
      result_nxt.status = STATUS_OVERFLOW;
    end else begin
      result_nxt.status = STATUS_OK;
    end
    result_nxt.min_depth    = depth_low_nxt;
    result_nxt.max_depth    = depth_high_nxt;
    result_nxt.wet_count    = wet_nxt;
    result_nxt.dry_count    = dry_nxt;
    result_nxt.min_surface  = (wet_nxt != '0) ? surf_low_nxt : 33'sd0;
    result_nxt.max_surface  = (wet_nxt != '0) ? surf_high_nxt : 33'sd0;
    result_nxt.peak_flow_x  = peak_x_nxt;
    result_nxt.peak_flow_z  = peak_z_nxt;
    result_nxt.volume       = vol_sum_nxt;
    result_nxt.total_flow_x = fx_sum_nxt;
    result_nxt.total_flow_z = fz_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && cell_data.last)) begin
      depth_low_r  <= S32_MAX;
      depth_high_r <= S32_MIN;
      wet_r        <= '0;
      dry_r        <= '0;
      surf_low_r   <= S33_MAX;
      surf_high_r  <= S33_MIN;
      peak_x_r     <= '0;
      peak_z_r     <= '0;
      vol_sum_r    <= '0;
      fx_sum_r     <= '0;
      fz_sum_r     <= '0;
      invalid_r    <= 1'b0;
      ovf_r        <= 1'b0;
    end else if (take) begin
      depth_low_r  <= depth_low_nxt;
      depth_high_r <= depth_high_nxt;
      wet_r        <= wet_nxt;
      dry_r        <= dry_nxt;
      surf_low_r   <= surf_low_nxt;
      surf_high_r  <= surf_high_nxt;
      peak_x_r     <= peak_x_nxt;
      peak_z_r     <= peak_z_nxt;
      vol_sum_r    <= vol_sum_nxt;
      fx_sum_r     <= fx_sum_nxt;
      fz_sum_r     <= fz_sum_nxt;
      invalid_r    <= invalid_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && cell_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cell_data.last) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

### sv/fluid_grid_statistics_reducer_top.sv
// ---------------------------------------------------------------------------
// fluid_grid_statistics_reducer_top
// Streaming min/max/sum reduction over the cells of a shallow-water grid.
//
//   channel | dir | per beat
//   --------+-----+------------------------------------------------------
//   in_     | in  | one cell: bed, depth, flow x, flow z; tlast = last cell
//   out_    | out | all statistics of one grid, after its last cell
//   cfg_    | in  | area write, single register
//
// One cell per cycle sustained, but for the wait of a last cell below.
// A result goes through input register, product register, result register.
// Reset (rst_n low, synchronous) clears the statistics; area -> 1.0.
// A last cell waits in the accumulate stage only while the previous result
// is still unread; the cells behind it wait with it.
// ---------------------------------------------------------------------------
module fluid_grid_statistics_reducer_top
  import fgsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,   // area
  input  logic             in_tvalid,
  output logic             in_tready,
  // bed_level, depth, flow_x, flow_z
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,      // last_cell
  output logic             out_tvalid,
  input  logic             out_tready,
  // status, min_depth, max_depth, wet_count, dry_count, min_surface,
  // max_surface, peak_flow_x, peak_flow_z, volume, total_flow_x,
  // total_flow_z, zero pad
  output logic [OUT_W-1:0] out_tdata
);

  logic    cell_valid;
  logic    cell_ready;
  cell_t   cell_data;
  result_t result;

  fgsr_cell_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cell_valid  (cell_valid),
    .cell_ready  (cell_ready),
    .cell_data   (cell_data)
  );

  fgsr_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_data  (cell_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  assign out_tdata = {6'd0, result};

endmodule

### verif/fluid_grid_statistics_reducer_top_tb.sv
// ---------------------------------------------------------------------------
// fluid_grid_statistics_reducer_top_tb
// Streams grids of cells into the reducer under bursty input and a stalling
// result side, predicts each grid's statistics beat in a local model and
// compares every result beat field by field. The cell area is changed
// between grids, once the block has drained.
// ---------------------------------------------------------------------------
module fluid_grid_statistics_reducer_top_tb;
  import fgsr_pkg::*;

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int ERR_INVALID  = 0;
  localparam int ERR_OVERFLOW = 1;
  localparam int RES_W        = $bits(result_t);

  typedef struct packed {
    logic signed [31:0] bed;
    logic signed [31:0] depth;
    logic signed [31:0] fx;
    logic signed [31:0] fz;
    logic               last;
  } cell_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [31:0]      cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // bed_level, depth, flow_x, flow_z
  logic             in_tlast = 1'b0; // last_cell
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // status, min_depth, max_depth, wet_count, dry_count, min_surface,
  // max_surface, peak_flow_x, peak_flow_z, volume, total_flow_x,
  // total_flow_z, zero pad
  logic [OUT_W-1:0] out_tdata;

  fluid_grid_statistics_reducer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cell_beat_t cell_queue[$];
  result_t    stats_expected[$];
  int         mismatch_count = 0;

  // grid statistics model
  logic [31:0]        area_reg = 32'h0001_0000;
  logic signed [31:0] depth_lo, depth_hi;
  logic [CNT_W-1:0]   wet_n, dry_n;
  logic signed [32:0] surf_lo, surf_hi;
  logic [31:0]        peak_x, peak_z;
  logic signed [63:0] vol_acc, fx_acc, fz_acc;
  logic [1:0]         err_bits;

  task automatic clear_grid_stats();
    depth_lo = S32_MAX;
    depth_hi = S32_MIN;
    wet_n    = '0;
    dry_n    = '0;
    surf_lo  = S33_MAX;
    surf_hi  = S33_MIN;
    peak_x   = '0;
    peak_z   = '0;
    vol_acc  = '0;
    fx_acc   = '0;
    fz_acc   = '0;
    err_bits = '0;
  endtask

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] acc,
                                                 input logic signed [31:0] val);
    logic signed [63:0] v64, a64, prod;
    logic signed [64:0] s;
    v64  = val;
    a64  = {32'd0, area_reg};
    prod = v64 * a64;
    s    = {acc[63], acc} + {prod[63], prod};
    if (s[64] != s[63]) begin
      err_bits[ERR_OVERFLOW] = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  task automatic accumulate_cell(input cell_beat_t c);
    logic               full;
    logic signed [32:0] b33, d33, surf;
    logic [31:0]        ax, az;
    result_t            r;
    full = (int'(wet_n) + int'(dry_n)) >= MAX_CELLS;
    ax   = c.fx[31] ? (~c.fx + 32'd1) : c.fx;
    az   = c.fz[31] ? (~c.fz + 32'd1) : c.fz;
    if (full || c.depth < 0) err_bits[ERR_INVALID] = 1'b1;
    if (c.depth < depth_lo) depth_lo = c.depth;
    if (c.depth > depth_hi) depth_hi = c.depth;
    if (c.depth > 0) begin
      b33  = c.bed;
      d33  = c.depth;
      surf = b33 + d33;
      if (!full) wet_n = wet_n + 1'b1;
      if (surf < surf_lo) surf_lo = surf;
      if (surf > surf_hi) surf_hi = surf;
    end else begin
      if (!full) dry_n = dry_n + 1'b1;
      if (c.fx != 0 || c.fz != 0) err_bits[ERR_INVALID] = 1'b1;
    end
    if (ax > peak_x) peak_x = ax;
    if (az > peak_z) peak_z = az;
    vol_acc = sat_sum(vol_acc, c.depth);
    fx_acc  = sat_sum(fx_acc, c.fx);
    fz_acc  = sat_sum(fz_acc, c.fz);
    if (c.last) begin
      if (err_bits[ERR_INVALID])       r.status = STATUS_INVALID;
      else if (err_bits[ERR_OVERFLOW]) r.status = STATUS_OVERFLOW;
      else                             r.status = STATUS_OK;
      r.min_depth    = depth_lo;
      r.max_depth    = depth_hi;
      r.wet_count    = wet_n;
      r.dry_count    = dry_n;
      r.min_surface  = (wet_n != 0) ? surf_lo : '0;
      r.max_surface  = (wet_n != 0) ? surf_hi : '0;
      r.peak_flow_x  = peak_x;
      r.peak_flow_z  = peak_z;
      r.volume       = vol_acc;
      r.total_flow_x = fx_acc;
      r.total_flow_z = fz_acc;
      stats_expected.push_back(r);
      clear_grid_stats();
    end
  endtask

  initial clear_grid_stats();

  // ---------------- input driver ----------------
  cell_beat_t  cur_cell;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) accumulate_cell(cur_cell);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cell_queue.size() != 0) begin
          cur_cell = cell_queue.pop_front();
          in_tdata  <= {cur_cell.fz, cur_cell.fx, cur_cell.depth, cur_cell.bed};
          in_tlast  <= cur_cell.last;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    result_t want, got;
    got = result_t'(out_tdata[RES_W-1:0]);
    if (stats_expected.size() == 0) begin
      report_mismatch("result beat with no grid pending", 64'd0, 64'd0);
      return;
    end
    want = stats_expected.pop_front();
    check_field("status", 64'(got.status), 64'(want.status));
    check_field("min_depth", 64'(got.min_depth), 64'(want.min_depth));
    check_field("max_depth", 64'(got.max_depth), 64'(want.max_depth));
    check_field("wet_count", 64'(got.wet_count), 64'(want.wet_count));
    check_field("dry_count", 64'(got.dry_count), 64'(want.dry_count));
    check_field("min_surface", 64'(got.min_surface), 64'(want.min_surface));
    check_field("max_surface", 64'(got.max_surface), 64'(want.max_surface));
    check_field("peak_flow_x", 64'(got.peak_flow_x), 64'(want.peak_flow_x));
    check_field("peak_flow_z", 64'(got.peak_flow_z), 64'(want.peak_flow_z));
    check_field("volume", got.volume, want.volume);
    check_field("total_flow_x", got.total_flow_x, want.total_flow_x);
    check_field("total_flow_z", got.total_flow_z, want.total_flow_z);
    check_field("pad", 64'(out_tdata[OUT_W-1:RES_W]), 64'd0);
  endtask

  int unsigned stall_mode = 0;
  int unsigned stall_timer = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(10, 80);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_tready <= ($urandom_range(0, 5) == 0);
        end
        default: begin
          out_tready <= ~out_tready;
        end
      endcase
    end
  end

  // ---------------- stimulus ----------------
  function automatic cell_beat_t make_cell(input logic [31:0] bed, input logic [31:0] depth,
                                           input logic [31:0] fx, input logic [31:0] fz,
                                           input logic last);
    cell_beat_t c;
    c.bed   = bed;
    c.depth = depth;
    c.fx    = fx;
    c.fz    = fz;
    c.last  = last;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hFFFF_FFFF;
      5: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 9))
      0, 1: return 32'd0;
      2: return {1'b1, 31'($urandom())};
      3: return rand_word();
      4, 5: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic queue_random_grid();
    int          len;
    logic [31:0] d, fx, fz;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      d = rand_depth();
      if ($signed(d) <= 0 && $urandom_range(0, 9) != 0) begin
        fx = 32'd0;
        fz = 32'd0;
      end else begin
        fx = rand_word();
        fz = rand_word();
      end
      cell_queue.push_back(make_cell(rand_word(), d, fx, fz, i == len - 1));
    end
  endtask

  task automatic wait_drained();
    while (cell_queue.size() != 0 || in_tvalid || stats_expected.size() != 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_cell_area(input logic [31:0] area);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= area;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    area_reg = area;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] areas[5];
    int          queued;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset area of 1.0
    cell_queue.push_back(make_cell(32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
    cell_queue.push_back(make_cell(S32_MAX, S32_MAX, S32_MIN, S32_MAX, 1'b1));
    cell_queue.push_back(make_cell(S32_MIN, S32_MIN, 32'd0, 32'd0, 1'b1));
    cell_queue.push_back(make_cell(32'd0, 32'd0, 32'd1, 32'd0, 1'b1));
    cell_queue.push_back(make_cell(32'd5, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1));
    cell_queue.push_back(make_cell(32'h0001_0000, 32'h0000_8000, 32'h0000_1000,
                                   -32'sd5, 1'b0));
    cell_queue.push_back(make_cell(S32_MIN, 32'd1, 32'd0, 32'd0, 1'b0));
    cell_queue.push_back(make_cell(32'd0, 32'd0, 32'd0, 32'd0, 1'b1));

    // largest area: sums saturate both ways, then overflow together with invalid
    set_cell_area(32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++)
      cell_queue.push_back(make_cell(32'd0, S32_MAX, S32_MIN, S32_MAX, i == 2));
    cell_queue.push_back(make_cell(32'd0, S32_MIN, 32'd0, 32'd0, 1'b0));
    cell_queue.push_back(make_cell(32'd0, S32_MIN, 32'd0, 32'd0, 1'b1));

    // zero area keeps all sums at zero
    set_cell_area(32'd0);
    cell_queue.push_back(make_cell(32'd1, 32'd100, 32'd3, -32'sd3, 1'b0));
    cell_queue.push_back(make_cell(32'd2, S32_MAX, S32_MIN, S32_MAX, 1'b1));

    areas[0] = 32'd1;
    areas[1] = $urandom();
    areas[2] = 32'hFFFF_FFFF;
    areas[3] = $urandom_range(1, 32'h0004_0000);
    areas[4] = 32'h0001_0000;
    foreach (areas[p]) begin
      set_cell_area(areas[p]);
      queued = 0;
      while (queued < 260) begin
        queue_random_grid();
        queued = cell_queue.size();
      end
    end

    wait_drained();
    if (stats_expected.size() != 0)
      report_mismatch("grid results never arrived", 64'(stats_expected.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
